[rtl/lnh_pkg.sv]
// lnh_pkg: shared constants, codes, state type and control/status structs
// for the letter n-gram histogram. No dependencies.
package lnh_pkg;

	localparam int ALPHABET_SIZE = 32;
	localparam int COUNTER_WIDTH = 32;

	localparam int BYTE_W    = 8;
	localparam int LETTER_W  = 5;
	localparam int VALUE_W   = 32;
	localparam int ACTION_W  = 2;
	localparam int ORDER_W   = 2;
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 8;

	localparam int UNI_AW    = LETTER_W;
	localparam int BI_AW     = 2 * LETTER_W;
	localparam int TRI_AW    = 3 * LETTER_W;
	localparam int UNI_DEPTH = 1 << UNI_AW;
	localparam int BI_DEPTH  = 1 << BI_AW;
	localparam int TRI_DEPTH = 1 << TRI_AW;

	localparam logic [BYTE_W-1:0]   LOWER_FIRST_RST = 8'd224;
	localparam logic [BYTE_W-1:0]   UPPER_FIRST_RST = 8'd192;
	localparam logic [BYTE_W-1:0]   EXTRA_CODE_RST  = 8'd184;
	localparam logic [LETTER_W-1:0] EXTRA_INDEX_RST = 5'd6;

	typedef logic [COUNTER_WIDTH-1:0] count_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_COUNT = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [ORDER_W-1:0] {
		ORD_NONE = 2'd0,
		ORD_UNI  = 2'd1,
		ORD_BI   = 2'd2,
		ORD_TRI  = 2'd3
	} order_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LOWER_FIRST = 2'd0,
		REG_UPPER_FIRST = 2'd1,
		REG_EXTRA_CODE  = 2'd2,
		REG_EXTRA_INDEX = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR,
		ST_HOLD
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;      // latch input word, launch RAM reads
		logic exec;        // read-modify-write cycle
		logic sweep;       // write zero at sweep address, advance
		logic sweep_done;  // clear total and history
		logic out_live;    // load output regs from live result
		logic stage_load;  // park live result in staging regs
		logic out_stage;   // load output regs from staging regs
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_clear;    // word at the input is a clear action
		logic sweep_last;  // sweep address at last entry
	} dp_stat_t;

endpackage

[rtl/lnh_ram.sv]
// lnh_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lnh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/lnh_ctrl.sv]
// lnh_ctrl: sequencer for the letter n-gram histogram; owns the handshakes.
// Depends on lnh_pkg.
module lnh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  lnh_pkg::dp_stat_t  stat,
	output lnh_pkg::dp_cmd_t   cmd
);

	lnh_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lnh_pkg::ST_INIT: begin
				if (stat.sweep_last) state_d = lnh_pkg::ST_IDLE;
			end
			lnh_pkg::ST_IDLE: begin
				if (in_valid) state_d = stat.in_clear ? lnh_pkg::ST_CLEAR : lnh_pkg::ST_EXEC;
			end
			lnh_pkg::ST_EXEC: begin
				state_d = out_free ? lnh_pkg::ST_IDLE : lnh_pkg::ST_HOLD;
			end
			lnh_pkg::ST_CLEAR: begin
				if (stat.sweep_last) state_d = out_free ? lnh_pkg::ST_IDLE : lnh_pkg::ST_HOLD;
			end
			lnh_pkg::ST_HOLD: begin
				if (out_free) state_d = lnh_pkg::ST_IDLE;
			end
			default: state_d = lnh_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		logic deliver;
		deliver        = (state_q == lnh_pkg::ST_EXEC) ||
		                 (state_q == lnh_pkg::ST_CLEAR && stat.sweep_last);
		in_stall       = (state_q != lnh_pkg::ST_IDLE);
		cmd.accept     = (state_q == lnh_pkg::ST_IDLE) && in_valid;
		cmd.exec       = (state_q == lnh_pkg::ST_EXEC);
		cmd.sweep      = (state_q == lnh_pkg::ST_INIT) || (state_q == lnh_pkg::ST_CLEAR);
		cmd.sweep_done = (state_q == lnh_pkg::ST_CLEAR) && stat.sweep_last;
		cmd.out_live   = deliver && out_free;
		cmd.stage_load = deliver && !out_free;
		cmd.out_stage  = (state_q == lnh_pkg::ST_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lnh_pkg::ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_live || cmd.out_stage) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/lnh_datapath.sv]
// lnh_datapath: byte folding, config registers, counter RAMs, history,
// total count and result/output registers. Depends on lnh_pkg, lnh_ram.
module lnh_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lnh_pkg::dp_cmd_t                   cmd,
	output lnh_pkg::dp_stat_t                  stat,
	input  logic                               cfg_write,
	input  logic [lnh_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [lnh_pkg::CFG_W-1:0]          cfg_data,
	input  logic [lnh_pkg::ACTION_W-1:0]       action,
	input  logic [lnh_pkg::BYTE_W-1:0]         letter_byte,
	input  logic [lnh_pkg::ORDER_W-1:0]        read_order,
	input  logic [lnh_pkg::TRI_AW-1:0]         read_index,
	output logic [lnh_pkg::VALUE_W-1:0]        value,
	output logic                               letter_valid,
	output logic [lnh_pkg::LETTER_W-1:0]       letter_index
);

	localparam int BW1 = lnh_pkg::BYTE_W + 1;
	localparam int LW1 = lnh_pkg::LETTER_W + 1;
	localparam int RW  = lnh_pkg::COUNTER_WIDTH + lnh_pkg::VALUE_W;
	localparam int LW  = lnh_pkg::LETTER_W;
	localparam int VW  = lnh_pkg::VALUE_W;

	function automatic lnh_pkg::count_t sat_inc(input lnh_pkg::count_t v);
		return (v == '1) ? v : v + lnh_pkg::count_t'(1);
	endfunction

	function automatic logic [VW-1:0] report(input lnh_pkg::count_t v);
		logic [RW-1:0] w;
		w = {{VW{1'b0}}, v};
		return (w > RW'({VW{1'b1}})) ? '1 : w[VW-1:0];
	endfunction

	function automatic logic in_alpha(input logic [LW-1:0] l);
		return {1'b0, l} < LW1'(lnh_pkg::ALPHABET_SIZE);
	endfunction

	// configuration
	logic [lnh_pkg::BYTE_W-1:0] lower_first_q, upper_first_q, extra_code_q;
	logic [LW-1:0]              extra_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_first_q <= lnh_pkg::LOWER_FIRST_RST;
			upper_first_q <= lnh_pkg::UPPER_FIRST_RST;
			extra_code_q  <= lnh_pkg::EXTRA_CODE_RST;
			extra_index_q <= lnh_pkg::EXTRA_INDEX_RST;
		end else if (cfg_write) begin
			case (lnh_pkg::reg_idx_t'(cfg_index))
				lnh_pkg::REG_LOWER_FIRST: lower_first_q <= cfg_data;
				lnh_pkg::REG_UPPER_FIRST: upper_first_q <= cfg_data;
				lnh_pkg::REG_EXTRA_CODE:  extra_code_q  <= cfg_data;
				lnh_pkg::REG_EXTRA_INDEX: extra_index_q <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// history and total
	logic [LW-1:0]   older_q, newer_q;
	logic            older_v_q, newer_v_q;
	lnh_pkg::count_t total_q;

	// fold: special code first, then lowercase, then uppercase range
	logic [lnh_pkg::BYTE_W-1:0] lo_off, up_off;
	logic                       fold_hit;
	logic [LW-1:0]              fold_idx;

	always_comb begin
		lo_off   = letter_byte - lower_first_q;
		up_off   = letter_byte - upper_first_q;
		fold_hit = 1'b0;
		fold_idx = '0;
		if (letter_byte == extra_code_q) begin
			if (in_alpha(extra_index_q)) begin
				fold_hit = 1'b1;
				fold_idx = extra_index_q;
			end
		end else if (letter_byte >= lower_first_q &&
		             {1'b0, lo_off} < BW1'(lnh_pkg::ALPHABET_SIZE)) begin
			fold_hit = 1'b1;
			fold_idx = lo_off[LW-1:0];
		end else if (letter_byte >= upper_first_q &&
		             {1'b0, up_off} < BW1'(lnh_pkg::ALPHABET_SIZE)) begin
			fold_hit = 1'b1;
			fold_idx = up_off[LW-1:0];
		end
	end

	// read addresses, chosen at accept
	logic                         is_read;
	logic                         rd_ok;
	logic [lnh_pkg::UNI_AW-1:0]   uni_ra;
	logic [lnh_pkg::BI_AW-1:0]    bi_ra;
	logic [lnh_pkg::TRI_AW-1:0]   tri_ra;

	assign is_read = (lnh_pkg::action_t'(action) == lnh_pkg::ACT_READ);

	always_comb begin
		case (lnh_pkg::order_t'(read_order))
			lnh_pkg::ORD_UNI: rd_ok = in_alpha(read_index[LW-1:0]);
			lnh_pkg::ORD_BI:  rd_ok = in_alpha(read_index[LW-1:0]) &&
			                          in_alpha(read_index[2*LW-1:LW]);
			lnh_pkg::ORD_TRI: rd_ok = in_alpha(read_index[LW-1:0]) &&
			                          in_alpha(read_index[2*LW-1:LW]) &&
			                          in_alpha(read_index[3*LW-1:2*LW]);
			default:          rd_ok = 1'b0;
		endcase
		uni_ra = is_read ? read_index[lnh_pkg::UNI_AW-1:0] : fold_idx;
		bi_ra  = is_read ? read_index[lnh_pkg::BI_AW-1:0]  : {newer_q, fold_idx};
		tri_ra = is_read ? read_index : {older_q, newer_q, fold_idx};
	end

	assign stat.in_clear = (lnh_pkg::action_t'(action) == lnh_pkg::ACT_CLEAR);

	// item registers
	lnh_pkg::action_t             act_s1;
	lnh_pkg::order_t              ord_s1;
	logic                         hit_s1, rd_ok_s1;
	logic [LW-1:0]                idx_s1;
	logic [lnh_pkg::UNI_AW-1:0]   uni_a_s1;
	logic [lnh_pkg::BI_AW-1:0]    bi_a_s1;
	logic [lnh_pkg::TRI_AW-1:0]   tri_a_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_s1   <= lnh_pkg::action_t'(action);
			ord_s1   <= lnh_pkg::order_t'(read_order);
			hit_s1   <= fold_hit;
			rd_ok_s1 <= rd_ok;
			idx_s1   <= fold_idx;
			uni_a_s1 <= uni_ra;
			bi_a_s1  <= bi_ra;
			tri_a_s1 <= tri_ra;
		end
	end

	// sweep address
	logic [lnh_pkg::TRI_AW-1:0] sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	assign stat.sweep_last = (sweep_q == '1);

	// counter memories
	logic            count_hit;
	logic            uni_we, bi_we, tri_we;
	lnh_pkg::count_t uni_rd, bi_rd, tri_rd;
	lnh_pkg::count_t uni_wd, bi_wd, tri_wd;

	assign count_hit = cmd.exec && (act_s1 == lnh_pkg::ACT_COUNT) && hit_s1;
	assign uni_we    = cmd.sweep || count_hit;
	assign bi_we     = cmd.sweep || (count_hit && newer_v_q);
	assign tri_we    = cmd.sweep || (count_hit && newer_v_q && older_v_q);
	assign uni_wd    = cmd.sweep ? '0 : sat_inc(uni_rd);
	assign bi_wd     = cmd.sweep ? '0 : sat_inc(bi_rd);
	assign tri_wd    = cmd.sweep ? '0 : sat_inc(tri_rd);

	lnh_ram #(.WIDTH(lnh_pkg::COUNTER_WIDTH), .DEPTH(lnh_pkg::UNI_DEPTH)) u_uni (
		.clk   (clk),
		.we    (uni_we),
		.waddr (cmd.sweep ? sweep_q[lnh_pkg::UNI_AW-1:0] : uni_a_s1),
		.wdata (uni_wd),
		.re    (cmd.accept),
		.raddr (uni_ra),
		.rdata (uni_rd)
	);

	lnh_ram #(.WIDTH(lnh_pkg::COUNTER_WIDTH), .DEPTH(lnh_pkg::BI_DEPTH)) u_bi (
		.clk   (clk),
		.we    (bi_we),
		.waddr (cmd.sweep ? sweep_q[lnh_pkg::BI_AW-1:0] : bi_a_s1),
		.wdata (bi_wd),
		.re    (cmd.accept),
		.raddr (bi_ra),
		.rdata (bi_rd)
	);

	lnh_ram #(.WIDTH(lnh_pkg::COUNTER_WIDTH), .DEPTH(lnh_pkg::TRI_DEPTH)) u_tri (
		.clk   (clk),
		.we    (tri_we),
		.waddr (cmd.sweep ? sweep_q : tri_a_s1),
		.wdata (tri_wd),
		.re    (cmd.accept),
		.raddr (tri_ra),
		.rdata (tri_rd)
	);

	// history and total update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			older_q   <= '0;
			newer_q   <= '0;
			older_v_q <= 1'b0;
			newer_v_q <= 1'b0;
		end else if (cmd.sweep_done) begin
			total_q   <= '0;
			older_q   <= '0;
			newer_q   <= '0;
			older_v_q <= 1'b0;
			newer_v_q <= 1'b0;
		end else if (count_hit) begin
			total_q   <= sat_inc(total_q);
			older_q   <= newer_q;
			older_v_q <= newer_v_q;
			newer_q   <= idx_s1;
			newer_v_q <= 1'b1;
		end
	end

	// live result
	logic [VW-1:0] res_value;
	logic          res_valid;
	logic [LW-1:0] res_index;

	always_comb begin
		res_value = report(total_q);
		res_valid = 1'b0;
		res_index = '0;
		case (act_s1)
			lnh_pkg::ACT_COUNT: begin
				if (hit_s1) begin
					res_value = report(sat_inc(total_q));
					res_valid = 1'b1;
					res_index = idx_s1;
				end
			end
			lnh_pkg::ACT_READ: begin
				case (ord_s1)
					lnh_pkg::ORD_UNI: res_value = report(uni_rd);
					lnh_pkg::ORD_BI:  res_value = report(bi_rd);
					lnh_pkg::ORD_TRI: res_value = report(tri_rd);
					default:          res_value = '0;
				endcase
				if (!rd_ok_s1) res_value = '0;
			end
			lnh_pkg::ACT_CLEAR: res_value = '0;
			default: ;
		endcase
	end

	// staging and output registers
	logic [VW-1:0] stage_value_q, value_q;
	logic          stage_valid_q, letter_valid_q;
	logic [LW-1:0] stage_index_q, letter_index_q;

	always_ff @(posedge clk) begin
		if (cmd.stage_load) begin
			stage_value_q <= res_value;
			stage_valid_q <= res_valid;
			stage_index_q <= res_index;
		end
		if (cmd.out_live) begin
			value_q        <= res_value;
			letter_valid_q <= res_valid;
			letter_index_q <= res_index;
		end else if (cmd.out_stage) begin
			value_q        <= stage_value_q;
			letter_valid_q <= stage_valid_q;
			letter_index_q <= stage_index_q;
		end
	end

	assign value        = value_q;
	assign letter_valid = letter_valid_q;
	assign letter_index = letter_index_q;

endmodule

[rtl/letter_ngram_histogram.sv]
// letter_ngram_histogram: top level, joins the sequencer and the datapath.
// Depends on lnh_pkg, lnh_ctrl, lnh_datapath (and lnh_ram below it).

// Letter n-gram histogram. Each input word carries an action. A count
// action folds letter_byte onto a letter index (the special code first,
// then the lowercase range, then the uppercase range; other bytes are
// ignored) and, for a letter, bumps the saturating unigram counter, the
// bigram counter once one earlier letter exists, the trigram counter once
// two exist, and the total; the result word returns the total and the
// folded letter. A read action returns one counter picked by read_order and
// read_index (oldest letter in the highest five bits). A clear action zeroes
// all counters, the total and the history and returns 0.
// For count, read and unused actions the accept cycle launches the reads of
// the three counter RAMs and, for a counted letter, the next cycle writes
// the incremented counters back through each RAM's write port. A clear
// action makes one zero write per cycle across the 32768-entry trigram RAM
// (smaller RAMs swept alongside), then returns its result. After reset the
// block runs the same clearing pass with in_stall high; configuration
// writes are taken throughout. A finished result sits in the output
// register, so the next word can be taken while the downstream side
// stalls. Configuration may be written only when idle.
module letter_ngram_histogram (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_write,
	input  logic [lnh_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [lnh_pkg::CFG_W-1:0]      cfg_data,
	// input words
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lnh_pkg::ACTION_W-1:0]   action,
	input  logic [lnh_pkg::BYTE_W-1:0]     letter_byte,
	input  logic [lnh_pkg::ORDER_W-1:0]    read_order,
	input  logic [lnh_pkg::TRI_AW-1:0]     read_index,
	// result words
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lnh_pkg::VALUE_W-1:0]    value,
	output logic                           letter_valid,
	output logic [lnh_pkg::LETTER_W-1:0]   letter_index
);

	lnh_pkg::dp_cmd_t  cmd;
	lnh_pkg::dp_stat_t stat;

	// sequencer: handshakes, RMW cycle, clearing sweep, output hand-off
	lnh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: folding, counter RAMs, history, result registers
	lnh_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.letter_byte  (letter_byte),
		.read_order   (read_order),
		.read_index   (read_index),
		.value        (value),
		.letter_valid (letter_valid),
		.letter_index (letter_index)
	);

endmodule

[rtl/lnh_checker.sv]
// lnh_checker: port-level assertions for letter_ngram_histogram, bound to
// the top level. Depends on lnh_pkg.
module lnh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [lnh_pkg::VALUE_W-1:0]   value,
	input logic                          letter_valid,
	input logic [lnh_pkg::LETTER_W-1:0]  letter_index
);

	// one word in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a word is still in work");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(value) &&
		$stable(letter_valid) && $stable(letter_index)))
		else $error("stalled result changed");

	// no letter, no index
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !letter_valid) |-> (letter_index == '0))
		else $error("letter index set without a letter");

	// a counted letter leaves the total at least one
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && letter_valid) |-> (value != '0))
		else $error("letter counted but total is zero");

endmodule

bind letter_ngram_histogram lnh_checker u_lnh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.value        (value),
	.letter_valid (letter_valid),
	.letter_index (letter_index)
);

[tb/lnh_tb_pkg.sv]
// lnh_tb_pkg: word and result types plus the n-gram histogram tracker class
// used by the testbench. Depends on lnh_pkg.
package lnh_tb_pkg;

	import lnh_pkg::*;

	typedef struct {
		action_t                act;
		logic [BYTE_W-1:0]      text_byte;
		order_t                 ord;
		logic [TRI_AW-1:0]      idx;
	} word_t;

	typedef struct {
		logic [VALUE_W-1:0]     value;
		logic                   letter_valid;
		logic [LETTER_W-1:0]    letter_index;
	} result_t;

	// Mirror of the histogram state; works out the result of every accepted
	// word and checks result words against that, oldest first.
	class ngram_tracker;
		logic [BYTE_W-1:0]   lower_first;
		logic [BYTE_W-1:0]   upper_first;
		logic [BYTE_W-1:0]   extra_code;
		logic [LETTER_W-1:0] extra_index;
		count_t              uni_cnt[UNI_DEPTH];
		count_t              bi_cnt[BI_DEPTH];
		count_t              tri_cnt[TRI_DEPTH];
		count_t              total;
		logic [LETTER_W-1:0] older;
		logic [LETTER_W-1:0] newer;
		bit                  older_ok;
		bit                  newer_ok;
		logic [TRI_AW-1:0]   recent;   // last three letters, newest lowest
		result_t             due[$];
		int                  checked;
		int                  errors;

		function new();
			lower_first = LOWER_FIRST_RST;
			upper_first = UPPER_FIRST_RST;
			extra_code  = EXTRA_CODE_RST;
			extra_index = EXTRA_INDEX_RST;
			recent      = '0;
			checked     = 0;
			errors      = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (uni_cnt[i]) uni_cnt[i] = '0;
			foreach (bi_cnt[i]) bi_cnt[i] = '0;
			foreach (tri_cnt[i]) tri_cnt[i] = '0;
			total    = '0;
			older    = '0;
			newer    = '0;
			older_ok = 1'b0;
			newer_ok = 1'b0;
		endfunction

		function void set_reg(reg_idx_t r, logic [CFG_W-1:0] d);
			case (r)
				REG_LOWER_FIRST: lower_first = d;
				REG_UPPER_FIRST: upper_first = d;
				REG_EXTRA_CODE:  extra_code = d;
				default:         extra_index = d[LETTER_W-1:0];
			endcase
		endfunction

		// special code wins, then lowercase, then uppercase
		function bit fold(logic [BYTE_W-1:0] b, output logic [LETTER_W-1:0] c);
			int dl;
			int du;
			dl = int'(b) - int'(lower_first);
			du = int'(b) - int'(upper_first);
			c = '0;
			if (b == extra_code) begin
				if (int'(extra_index) >= ALPHABET_SIZE) return 1'b0;
				c = extra_index;
				return 1'b1;
			end
			if (dl >= 0 && dl < ALPHABET_SIZE) begin
				c = dl[LETTER_W-1:0];
				return 1'b1;
			end
			if (du >= 0 && du < ALPHABET_SIZE) begin
				c = du[LETTER_W-1:0];
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// false for words the block only passes over
		function bit is_active(word_t w);
			logic [LETTER_W-1:0] c;
			case (w.act)
				ACT_COUNT: return fold(w.text_byte, c);
				ACT_READ, ACT_CLEAR: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function count_t bump(count_t v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function logic [VALUE_W-1:0] to_value(count_t v);
			logic [63:0] w;
			w = 64'(v);
			return (w > 64'hFFFF_FFFF) ? '1 : w[VALUE_W-1:0];
		endfunction

		function void log_word(word_t w);
			result_t             e;
			logic [LETTER_W-1:0] c;
			e.value        = to_value(total);
			e.letter_valid = 1'b0;
			e.letter_index = '0;
			case (w.act)
				ACT_COUNT: begin
					if (fold(w.text_byte, c)) begin
						total      = bump(total);
						uni_cnt[c] = bump(uni_cnt[c]);
						if (newer_ok)
							bi_cnt[{newer, c}] = bump(bi_cnt[{newer, c}]);
						if (older_ok && newer_ok)
							tri_cnt[{older, newer, c}] = bump(tri_cnt[{older, newer, c}]);
						older    = newer;
						older_ok = newer_ok;
						newer    = c;
						newer_ok = 1'b1;
						recent   = {recent[TRI_AW-LETTER_W-1:0], c};
						e.value        = to_value(total);
						e.letter_valid = 1'b1;
						e.letter_index = c;
					end
				end
				ACT_READ: begin
					case (w.ord)
						ORD_UNI: e.value = to_value(uni_cnt[w.idx[UNI_AW-1:0]]);
						ORD_BI:  e.value = to_value(bi_cnt[w.idx[BI_AW-1:0]]);
						ORD_TRI: e.value = to_value(tri_cnt[w.idx]);
						default: e.value = '0;
					endcase
				end
				ACT_CLEAR: begin
					wipe();
					e.value = '0;
				end
				default: ;
			endcase
			due = {due, e};
		endfunction

		function void check_result(logic [VALUE_W-1:0] v, logic lv, logic [LETTER_W-1:0] li);
			result_t e;
			checked++;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %0d: nothing expected, got value %0d valid %0b letter %0d",
						checked, v, lv, li);
				return;
			end
			e = due.pop_front();
			if (v !== e.value || lv !== e.letter_valid || li !== e.letter_index) begin
				errors++;
				if (errors <= 10)
					$display("result %0d: expected value %0d valid %0b letter %0d, got value %0d valid %0b letter %0d",
						checked, e.value, e.letter_valid, e.letter_index, v, lv, li);
			end
		endfunction
	endclass

endpackage

[tb/letter_ngram_histogram_tb.sv]
// letter_ngram_histogram_tb: drives count, read, clear and unused words under random
// gaps and stalls, and checks every result word against the tracker.
// Depends on lnh_pkg, lnh_tb_pkg and the letter_ngram_histogram RTL.
module letter_ngram_histogram_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import lnh_pkg::*;
	import lnh_tb_pkg::*;

	localparam int N_PHASES    = 7;
	localparam int PER_PHASE   = 153;   // active random words per register setting
	localparam int HOLD_AFTER  = 300;   // results seen before the long output hold
	localparam int HOLD_CYCLES = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [ACTION_W-1:0]   action;
	logic [BYTE_W-1:0]     letter_byte;
	logic [ORDER_W-1:0]    read_order;
	logic [TRI_AW-1:0]     read_index;
	logic                  out_valid;
	logic                  out_stall;
	logic [VALUE_W-1:0]    value;
	logic                  letter_valid;
	logic [LETTER_W-1:0]   letter_index;

	ngram_tracker track = new();

	int burst_left  = 0;      // sender: words left in a back-to-back run
	int clears_left = 5;      // each clear costs a full sweep, keep them rare
	int pool        = 4;      // narrow letter set so n-gram counts build up
	bit long_hold   = 1'b0;   // receiver is in its long hold; sender presses on

	letter_ngram_histogram dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.letter_byte  (letter_byte),
		.read_order   (read_order),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.letter_valid (letter_valid),
		.letter_index (letter_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short idle spells, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Gap after an accepted word. Runs of back-to-back words keep the block
	// busy; during the long output hold the sender never lets up.
	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (long_hold) return 0;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if (r < 10) begin
			burst_left = $urandom_range(10, 50);
			return 0;
		end
		if (r < 45) return 0;
		return idle_len();
	endfunction

	function automatic word_t mk(action_t a, int b, order_t o, int i);
		word_t w;
		w.act       = a;
		w.text_byte = 8'(b);
		w.ord       = o;
		w.idx       = 15'(i);
		return w;
	endfunction

	// Random word. Count words mostly hit the letter ranges of the current
	// setting; reads mostly aim at n-grams that were just counted, with
	// junk in the index bits that the order ignores.
	function automatic word_t make_word();
		word_t               w;
		int                  r;
		int                  sel;
		logic [LETTER_W-1:0] off;
		r           = $urandom_range(0, 99);
		w.act       = ACT_COUNT;
		w.text_byte = 8'($urandom);
		w.ord       = order_t'($urandom_range(0, 3));
		w.idx       = 15'($urandom);
		off = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, pool - 1));
		if (r < 72) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				w.text_byte = track.lower_first + 8'(off);
			else if (sel < 65)
				w.text_byte = track.upper_first + 8'(off);
			else if (sel < 77)
				w.text_byte = track.extra_code;
			// otherwise a raw byte: mostly ignored noise
		end else if (r < 92) begin
			w.act = ACT_READ;
			w.ord = ($urandom_range(0, 19) == 0) ? ORD_NONE : order_t'($urandom_range(1, 3));
			if ($urandom_range(0, 99) < 65) begin
				case (w.ord)
					ORD_UNI: w.idx[UNI_AW-1:0] = track.recent[UNI_AW-1:0];
					ORD_BI:  w.idx[BI_AW-1:0] = track.recent[BI_AW-1:0];
					default: w.idx = track.recent;
				endcase
			end
		end else if (r < 99 || clears_left == 0) begin
			w.act = ACT_NONE;
		end else begin
			w.act = ACT_CLEAR;
			clears_left--;
		end
		return w;
	endfunction

	// Offer one word and hold it until taken. valid only drops when a gap
	// follows, so back-to-back words never see valid toggle in one step.
	task automatic send_word(input word_t w, input bit last);
		int gap;
		in_valid    <= 1'b1;
		action      <= w.act;
		letter_byte <= w.text_byte;
		read_order  <= w.ord;
		read_index  <= w.idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track.log_word(w);
		gap = next_gap();
		if (last && gap == 0) gap = 1;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_reg(input reg_idx_t r, input logic [CFG_W-1:0] d);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		@(posedge clk);
		track.set_reg(r, d);
	endtask

	// Top bits of the extra index write are junk; only five bits stick.
	task automatic write_regs(input logic [7:0] lf, input logic [7:0] uf,
			input logic [7:0] ec, input logic [4:0] ei);
		put_reg(REG_LOWER_FIRST, lf);
		put_reg(REG_UPPER_FIRST, uf);
		put_reg(REG_EXTRA_CODE, ec);
		put_reg(REG_EXTRA_INDEX, {3'($urandom), ei});
		cfg_write <= 1'b0;
	endtask

	// Every word gives one result, so once the last one is back the block
	// is idle; a few spare cycles cover the write-back.
	task automatic drain();
		while (track.due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Result side: checks each taken result word and stalls at random, with
	// calm stretches, plus one long hold so the block backs up its input.
	initial begin : result_sink
		int stall_left;
		int calm_left;
		int hold_left;
		int seen;
		bit held;
		stall_left = 0;
		calm_left  = 0;
		hold_left  = 0;
		seen       = 0;
		held       = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				track.check_result(value, letter_valid, letter_index);
				seen++;
			end
			if (!held && seen >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				long_hold = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				long_hold = (hold_left > 0);
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
				out_stall <= 1'b0;
			end else begin
				if ($urandom_range(0, 99) < 40)
					calm_left = $urandom_range(5, 80);
				else
					stall_left = idle_len();
				out_stall <= 1'b0;
			end
		end
	end

	// The worst case covers ~1350 words each waiting out the longest gap and
	// stall, six clear sweeps and the clearing pass after reset. The limit
	// takes that six times over.
	initial begin : watchdog
		#30_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		word_t dir[$];
		word_t w;
		int    ph;
		int    n;
		bit    active;
		arst_n      <= 1'b0;
		cfg_write   <= 1'b0;
		cfg_index   <= REG_LOWER_FIRST;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		action      <= ACT_COUNT;
		letter_byte <= '0;
		read_order  <= ORD_NONE;
		read_index  <= '0;

		// Directed words at the reset setting. Letters counted: 0 31 0 31 6.
		dir = '{
			mk(ACT_COUNT, LOWER_FIRST_RST, ORD_NONE, 0),          // first lowercase
			mk(ACT_COUNT, 255, ORD_NONE, 0),                      // last lowercase, top byte
			mk(ACT_COUNT, UPPER_FIRST_RST, ORD_NONE, 0),          // uppercase, same letter
			mk(ACT_COUNT, UPPER_FIRST_RST + 31, ORD_NONE, 0),
			mk(ACT_COUNT, EXTRA_CODE_RST, ORD_NONE, 0),           // special code
			mk(ACT_COUNT, 0, ORD_NONE, 0),                        // ignored bytes
			mk(ACT_COUNT, UPPER_FIRST_RST - 1, ORD_TRI, 32767),
			mk(ACT_NONE, LOWER_FIRST_RST, ORD_UNI, 0),            // unused action
			mk(ACT_READ, 0, ORD_UNI, 0),
			mk(ACT_READ, 0, ORD_UNI, 32767),                      // upper index bits ignored
			mk(ACT_READ, 0, ORD_BI, {5'd31, 5'd0, 5'd31}),
			mk(ACT_READ, 0, ORD_TRI, {5'd0, 5'd31, 5'd0}),
			mk(ACT_READ, 0, ORD_TRI, {5'd31, 5'd0, 5'd31}),
			mk(ACT_READ, 0, ORD_TRI, {5'd0, 5'd31, 5'd6}),
			mk(ACT_READ, 0, ORD_NONE, 0),                         // bad order reads zero
			mk(ACT_READ, 0, ORD_NONE, 32767),
			mk(ACT_CLEAR, 0, ORD_NONE, 0),
			mk(ACT_READ, 0, ORD_UNI, 0),
			mk(ACT_READ, 0, ORD_TRI, {5'd0, 5'd31, 5'd6}),
			mk(ACT_COUNT, LOWER_FIRST_RST + 1, ORD_NONE, 0),      // history restarts
			mk(ACT_COUNT, LOWER_FIRST_RST + 2, ORD_NONE, 0),
			mk(ACT_READ, 0, ORD_BI, {5'd1, 5'd2}),
			mk(ACT_READ, 0, ORD_BI, {5'd31, 5'd6})                // wiped by the clear
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (ph = 0; ph < N_PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: write_regs(8'd97, 8'd65, 8'd33, 5'd6);      // plain ASCII, '!' special
					2: write_regs(8'd255, 8'd0, 8'd0, 5'd31);      // lowercase cut at 255
					3: write_regs(8'd0, 8'd255, 8'd255, 5'd0);
					4: write_regs(8'd240, 8'd240, 8'd250, 5'($urandom)); // overlapping ranges
					5: write_regs(8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
					default: write_regs(LOWER_FIRST_RST, UPPER_FIRST_RST, EXTRA_CODE_RST,
						EXTRA_INDEX_RST);
				endcase
			end
			pool = $urandom_range(2, 6);
			if (ph == 0)
				foreach (dir[i]) send_word(dir[i], i == dir.size() - 1);
			n = 0;
			while (n < PER_PHASE) begin
				w      = make_word();
				active = track.is_active(w);
				if (active) n++;
				send_word(w, active && n == PER_PHASE);
			end
		end

		drain();
		if (track.errors == 0 && track.due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[letter_ngram_histogram.f]
rtl/lnh_pkg.sv
rtl/lnh_ram.sv
rtl/lnh_ctrl.sv
rtl/lnh_datapath.sv
rtl/letter_ngram_histogram.sv
rtl/lnh_checker.sv
tb/lnh_tb_pkg.sv
tb/letter_ngram_histogram_tb.sv
